// ===== src/pbc_pkg.sv =====
package pbc_pkg;

  localparam int LOOP_W    = 16;
  localparam int REG_IDX_W = 16;
  localparam int CMD_W     = 3;

  // Multiplier of the set hash (golden-ratio constant).
  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 3'd0,
    CMD_STORE  = 3'd1,
    CMD_BUMP   = 3'd2,
    CMD_TYPED  = 3'd3,
    CMD_CLEAR  = 3'd4
  } pbc_cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUO,
    ST_RED,
    ST_EXEC
  } pbc_state_t;

  typedef struct packed {
    pbc_cmd_t              cmd;
    logic [LOOP_W-1:0]     loop_key;
    logic [REG_IDX_W-1:0]  reg_index;
    logic                  in_range;
    logic                  is_bool;
    logic                  bool_value;
    logic                  fastpath;
  } pbc_req_t;

  typedef struct packed {
    logic row_we;
    logic gen_we;
    logic hit;
    logic pred_value;
  } pbc_resp_t;

endpackage

// ===== src/pbc_row_update.sv =====
module pbc_row_update
  import pbc_pkg::*;
#(
  parameter int WAYS     = 4,
  parameter int GEN_BITS = 32,
  parameter int SREG_W   = 8,
  localparam int EW      = 1 + LOOP_W + SREG_W + GEN_BITS,
  localparam int ROW_W   = WAYS * EW,
  localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  pbc_req_t            req,
  input  logic [ROW_W-1:0]    row_i,
  input  logic [GEN_BITS-1:0] gen_i,
  input  logic [WW-1:0]       dflt_way,
  output logic [ROW_W-1:0]    row_o,
  output logic [GEN_BITS-1:0] gen_o,
  output pbc_resp_t           resp
);

  logic [WAYS-1:0]     vld;
  logic [WAYS-1:0]     mt;
  logic [GEN_BITS-1:0] gn [WAYS];

  logic          m_found;
  logic          f_found;
  logic [WW-1:0] m_way;
  logic [WW-1:0] f_way;
  logic [WW-1:0] sel_way;
  logic          ok;

  // Each entry is {valid, loop, register, generation}, way 0 in the low bits.
  for (genvar w = 0; w < WAYS; w++) begin : g_way
    logic [LOOP_W-1:0] lp;
    logic [SREG_W-1:0] sr;
    assign vld[w] = row_i[w*EW + EW - 1];
    assign lp     = row_i[w*EW + SREG_W + GEN_BITS +: LOOP_W];
    assign sr     = row_i[w*EW + GEN_BITS +: SREG_W];
    assign gn[w]  = row_i[w*EW +: GEN_BITS];
    assign mt[w]  = vld[w] && (lp == req.loop_key) &&
                    (sr == req.reg_index[SREG_W-1:0]) && req.in_range;
  end

  // Lowest matching way and lowest free way.
  always_comb begin
    m_found = 1'b0;
    m_way   = '0;
    f_found = 1'b0;
    f_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (mt[w]) begin
        m_found = 1'b1;
        m_way   = WW'(w);
      end
      if (!vld[w]) begin
        f_found = 1'b1;
        f_way   = WW'(w);
      end
    end
  end

  assign ok      = req.in_range && req.is_bool;
  assign sel_way = m_found ? m_way : (f_found ? f_way : dflt_way);
  assign gen_o   = gen_i + GEN_BITS'(1);

  always_comb begin
    row_o = row_i;
    resp  = '0;
    case (req.cmd)
      CMD_LOOKUP: begin
        if (req.fastpath && m_found) begin
          if (!ok || (gn[m_way] != gen_i)) begin
            row_o[int'(m_way)*EW + EW - 1] = 1'b0;
            resp.row_we = 1'b1;
          end else begin
            resp.hit        = 1'b1;
            resp.pred_value = req.bool_value;
          end
        end
      end
      CMD_STORE: begin
        if (ok) begin
          row_o[int'(sel_way)*EW +: EW] = {1'b1, req.loop_key,
                                           req.reg_index[SREG_W-1:0], gen_i};
          resp.row_we = 1'b1;
        end
      end
      CMD_BUMP: begin
        resp.gen_we = req.in_range;
      end
      CMD_TYPED: begin
        if (req.fastpath && req.in_range) begin
          if (req.is_bool) begin
            resp.hit        = 1'b1;
            resp.pred_value = req.bool_value;
          end else begin
            resp.gen_we = 1'b1;
          end
        end
      end
      default: begin
        resp = '0;
      end
    endcase
  end

endmodule

// ===== src/predicate_branch_cache.sv =====
// Predicate branch cache: a set-associative cache of (loop, predicate register)
// pairs with a generation counter per register. Each input transaction carries
// one command (lookup, store, bump generation, typed check or clear all) and
// yields exactly one result transaction (hit, pred_value). The slots live in a
// row memory of BUCKETS rows, one row holding all WAYS slots of a set, and the
// generations in a second memory of REG_COUNT words; both have a registered
// read port, and every command is a read, modify and write-back of one row and
// one generation word. With BUCKETS a power of two the row read is issued at
// acceptance, and the modify and write-back follow in ST_EXEC once the output
// register is free. Otherwise the set index needs a reciprocal-multiply
// reduction of the hash in ST_QUO and ST_RED, which issues the row read, before
// ST_EXEC. After reset, and after each clear-all command, a clearing pass
// zeroes both memories one word per cycle, taking no input while it runs;
// configuration writes are accepted at any time. A finished result sits in an
// output register, so the next transaction may be accepted before the
// previous result has been taken.
module predicate_branch_cache
  import pbc_pkg::*;
#(
  parameter int BUCKETS   = 64,
  parameter int WAYS      = 4,
  parameter int REG_COUNT = 256,
  parameter int GEN_BITS  = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [LOOP_W-1:0]    in_loop_key,
  input  logic [REG_IDX_W-1:0] in_reg_index,
  input  logic                 in_reg_is_bool,
  input  logic                 in_reg_bool_value,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic                 out_pred_value,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_fastpath_enable
);

  localparam int  SW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int  GIDX_W  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int  WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int  EW      = 1 + LOOP_W + GIDX_W + GEN_BITS;
  localparam int  ROW_W   = WAYS * EW;
  localparam int  CLR_N   = (BUCKETS > REG_COUNT) ? BUCKETS : REG_COUNT;
  localparam int  CW      = (CLR_N > 1) ? $clog2(CLR_N) : 1;
  localparam bit  B_POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);
  // Reciprocals for the set and default-way reductions. Each estimated
  // quotient is at most one short, so one compare and subtract corrects it.
  localparam logic [31:0] B_RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));
  localparam logic [16:0] W_RECIP = 17'((32'd1 << 16) / 32'(WAYS));

  pbc_state_t state_r, state_nxt;
  logic [CW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clr_last;

  // Accepted transaction.
  logic [CMD_W-1:0]     cmd_r;
  logic [LOOP_W-1:0]    loop_r;
  logic [REG_IDX_W-1:0] reg_r;
  logic                 is_bool_r;
  logic                 bool_val_r;
  logic [31:0]          hash_r;
  logic [31:0]          quo_r;
  logic [15:0]          wq_r;
  logic [SW-1:0]        set_r;

  logic                 fastpath_r;
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic                 out_pred_r;

  // Memories and their registered read data.
  logic [ROW_W-1:0]    row_mem [BUCKETS];
  logic [GEN_BITS-1:0] gen_mem [REG_COUNT];
  logic [ROW_W-1:0]    row_q_r;
  logic [GEN_BITS-1:0] gen_q_r;

  logic                 in_fire;
  logic                 out_free;
  logic                 commit;
  logic [31:0]          hash_comb;
  logic [SW-1:0]        set_acc;
  logic [SW-1:0]        set_red;
  logic [32:0]          red_rem;
  logic [32:0]          red_fix;
  logic [16:0]          way_rem;
  logic [16:0]          way_fix;
  logic [WW-1:0]        dflt_way;
  logic                 row_rd_en;
  logic [SW-1:0]        row_rd_addr;
  logic                 row_wr_en;
  logic [SW-1:0]        row_wr_addr;
  logic [ROW_W-1:0]     row_wr_data;
  logic                 gen_wr_en;
  logic [GIDX_W-1:0]    gen_wr_addr;
  logic [GEN_BITS-1:0]  gen_wr_data;
  logic                 clr_row;
  logic                 clr_gen;
  logic [ROW_W-1:0]     row_new;
  logic [GEN_BITS-1:0]  gen_new;
  pbc_req_t             req;
  pbc_resp_t            resp;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign clr_last = (clr_cnt_r == CW'(CLR_N - 1));
  assign clr_row  = (32'(clr_cnt_r) < 32'(BUCKETS));
  assign clr_gen  = (32'(clr_cnt_r) < 32'(REG_COUNT));

  // Hash key is {loop, register}; only the low 32 bits of the product count.
  assign hash_comb = 32'({in_loop_key, in_reg_index} * HASH_MULT);
  assign set_acc   = (BUCKETS == 1) ? '0 : hash_comb[SW-1:0];

  // Remainder of the hash by BUCKETS from the registered quotient estimate.
  assign red_rem = 33'(hash_r) - 33'(quo_r) * 33'(BUCKETS);
  assign red_fix = (red_rem >= 33'(BUCKETS)) ? red_rem - 33'(BUCKETS) : red_rem;
  assign set_red = red_fix[SW-1:0];

  // Fallback way for a store into a full set: register index modulo WAYS.
  assign way_rem  = 17'(reg_r) - 17'(wq_r) * 17'(WAYS);
  assign way_fix  = (way_rem >= 17'(WAYS)) ? way_rem - 17'(WAYS) : way_rem;
  assign dflt_way = way_fix[WW-1:0];

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = B_POW2 ? ST_EXEC : ST_QUO;
        end
      end
      ST_QUO: begin
        state_nxt = ST_RED;
      end
      ST_RED: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = (cmd_r == CMD_CLEAR) ? ST_CLEAR : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready    = 1'b0;
    row_rd_en   = 1'b0;
    row_rd_addr = set_acc;
    commit      = 1'b0;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_last ? '0 : clr_cnt_r + CW'(1);
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        row_rd_en = in_valid && B_POW2;
      end
      ST_RED: begin
        row_rd_en   = 1'b1;
        row_rd_addr = set_red;
      end
      ST_EXEC: begin
        commit = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign req.cmd        = pbc_cmd_t'(cmd_r);
  assign req.loop_key   = loop_r;
  assign req.reg_index  = reg_r;
  assign req.in_range   = ({1'b0, reg_r} < 17'(REG_COUNT));
  assign req.is_bool    = is_bool_r;
  assign req.bool_value = bool_val_r;
  assign req.fastpath   = fastpath_r;

  pbc_row_update #(
    .WAYS     (WAYS),
    .GEN_BITS (GEN_BITS),
    .SREG_W   (GIDX_W)
  ) u_row_update (
    .req      (req),
    .row_i    (row_q_r),
    .gen_i    (gen_q_r),
    .dflt_way (dflt_way),
    .row_o    (row_new),
    .gen_o    (gen_new),
    .resp     (resp)
  );

  // Write ports: the clearing pass owns them while it runs.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      row_wr_en   = clr_row;
      row_wr_addr = clr_cnt_r[SW-1:0];
      row_wr_data = '0;
      gen_wr_en   = clr_gen;
      gen_wr_addr = clr_cnt_r[GIDX_W-1:0];
      gen_wr_data = '0;
    end else begin
      row_wr_en   = commit && resp.row_we;
      row_wr_addr = set_r;
      row_wr_data = row_new;
      gen_wr_en   = commit && resp.gen_we;
      gen_wr_addr = reg_r[GIDX_W-1:0];
      gen_wr_data = gen_new;
    end
  end

  always_ff @(posedge clk) begin
    if (row_wr_en) begin
      row_mem[row_wr_addr] <= row_wr_data;
    end
    if (row_rd_en) begin
      row_q_r <= row_mem[row_rd_addr];
    end
  end

  // The generation word is read at acceptance; an out-of-range index reads a
  // word that is never used.
  always_ff @(posedge clk) begin
    if (gen_wr_en) begin
      gen_mem[gen_wr_addr] <= gen_wr_data;
    end
    if (in_fire) begin
      gen_q_r <= gen_mem[in_reg_index[GIDX_W-1:0]];
    end
  end

  // Transaction payload and set computation.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r      <= in_cmd;
      loop_r     <= in_loop_key;
      reg_r      <= in_reg_index;
      is_bool_r  <= in_reg_is_bool;
      bool_val_r <= in_reg_bool_value;
      hash_r     <= hash_comb;
      set_r      <= set_acc;
      wq_r       <= 16'((33'(in_reg_index) * 33'(W_RECIP)) >> 16);
    end
    if (state_r == ST_QUO) begin
      quo_r <= 32'((64'(hash_r) * 64'(B_RECIP)) >> 32);
    end
    if (state_r == ST_RED) begin
      set_r <= set_red;
    end
    if (commit) begin
      out_hit_r  <= resp.hit;
      out_pred_r <= resp.pred_value;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      fastpath_r  <= 1'b1;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        fastpath_r <= cfg_fastpath_enable;
      end
    end
  end

  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_pred_value = out_pred_r;

endmodule

// ===== tb/sv/tb_predicate_branch_cache.sv =====
`timescale 1ns / 1ps

module tb_predicate_branch_cache
  import pbc_pkg::*;
();

  // Geometry of the block under test. The tracker below mirrors it exactly.
  localparam int BUCKETS   = 64;
  localparam int WAYS      = 4;
  localparam int REG_COUNT = 256;
  localparam int GEN_BITS  = 32;
  localparam int SLOTS     = BUCKETS * WAYS;

  // Command codes 5 to 7 are left unused by the block and must do nothing.
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_W'(CMD_CLEAR + 1);
  localparam logic [CMD_W-1:0] CMD_LAST         = {CMD_W{1'b1}};

  // Timing knobs. The settle pause covers the read, modify and write-back of
  // the last transaction; the limit is far beyond the slowest correct run,
  // clearing passes and the long output hold-off included.
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int IDLE_PERCENT  = 23;

  // One command as it crosses the input channel.
  typedef struct {
    logic [CMD_W-1:0]     cmd;
    logic [LOOP_W-1:0]    loop_key;
    logic [REG_IDX_W-1:0] reg_index;
    logic                 is_bool;
    logic                 bool_value;
  } cache_cmd_t;

  // One result as it leaves on the output channel.
  typedef struct {
    logic hit;
    logic pred_value;
  } cache_outcome_t;

  // The tracker keeps its own copy of the slot store, the generation words and
  // the fastpath switch. Every accepted command is applied to it in order, and
  // the result that the command must produce is queued for the output side.
  class branch_cache_tracker;
    bit                   slot_valid [SLOTS];
    logic [LOOP_W-1:0]    slot_loop  [SLOTS];
    logic [REG_IDX_W-1:0] slot_reg   [SLOTS];
    logic [GEN_BITS-1:0]  slot_gen   [SLOTS];
    logic [GEN_BITS-1:0]  reg_gen    [REG_COUNT];
    bit                   fastpath;
    cache_outcome_t       awaited_outcomes[$];
    int                   failures;

    function new();
      wipe();
      fastpath = 1'b1;
      failures = 0;
    endfunction

    function void wipe();
      foreach (slot_valid[s]) begin
        slot_valid[s] = 1'b0;
        slot_loop[s]  = '0;
        slot_reg[s]   = '0;
        slot_gen[s]   = '0;
      end
      foreach (reg_gen[r]) reg_gen[r] = '0;
    endfunction

    function void set_fastpath(bit enable);
      fastpath = enable;
    endfunction

    function int pending();
      return awaited_outcomes.size();
    endfunction

    // First slot of the set: multiplicative hash of the packed key, reduced
    // modulo the bucket count, then scaled by the number of ways.
    function int set_base(logic [LOOP_W-1:0] loop_key, logic [REG_IDX_W-1:0] reg_index);
      logic [31:0] key;
      key = {loop_key, 16'h0000} ^ {16'h0000, reg_index};
      key = key * HASH_MULT;
      return int'(key % BUCKETS) * WAYS;
    endfunction

    function int find_slot(int base, logic [LOOP_W-1:0] loop_key,
                           logic [REG_IDX_W-1:0] reg_index);
      for (int w = 0; w < WAYS; w++)
        if (slot_valid[base + w] && slot_loop[base + w] == loop_key &&
            slot_reg[base + w] == reg_index)
          return base + w;
      return -1;
    endfunction

    function void bump_generation(logic [REG_IDX_W-1:0] reg_index);
      if (reg_index < REG_COUNT)
        reg_gen[reg_index] = reg_gen[reg_index] + 1'b1;
    endfunction

    function void complain(string msg);
      failures++;
      $display("%0t ns: %s", $time, msg);
    endfunction

    // Applies one accepted command and queues the result it must yield.
    function void note_command(cache_cmd_t c);
      cache_outcome_t outcome;
      bit             in_range;
      int             base;
      int             s;
      outcome  = '{hit: 1'b0, pred_value: 1'b0};
      in_range = c.reg_index < REG_COUNT;
      base     = set_base(c.loop_key, c.reg_index);
      s        = find_slot(base, c.loop_key, c.reg_index);
      case (c.cmd)
        CMD_LOOKUP: begin
          if (fastpath) begin
            if (!in_range || !c.is_bool) begin
              if (s >= 0) slot_valid[s] = 1'b0;
            end else if (s >= 0) begin
              // A stale generation kills the slot rather than reporting it.
              if (slot_gen[s] != reg_gen[c.reg_index]) begin
                slot_valid[s] = 1'b0;
              end else begin
                outcome.hit        = 1'b1;
                outcome.pred_value = c.bool_value;
              end
            end
          end
        end
        CMD_STORE: begin
          if (in_range && c.is_bool) begin
            // Matching slot first, then the lowest free way, then evict the
            // way picked by the register number.
            for (int w = 0; w < WAYS && s < 0; w++)
              if (!slot_valid[base + w]) s = base + w;
            if (s < 0) s = base + int'(c.reg_index % WAYS);
            slot_valid[s] = 1'b1;
            slot_loop[s]  = c.loop_key;
            slot_reg[s]   = c.reg_index;
            slot_gen[s]   = reg_gen[c.reg_index];
          end
        end
        CMD_BUMP: bump_generation(c.reg_index);
        CMD_TYPED: begin
          if (fastpath && in_range) begin
            if (c.is_bool) begin
              outcome.hit        = 1'b1;
              outcome.pred_value = c.bool_value;
            end else begin
              bump_generation(c.reg_index);
            end
          end
        end
        CMD_CLEAR: wipe();
        default: ;
      endcase
      awaited_outcomes.push_back(outcome);
    endfunction

    // Compares one accepted result with the oldest outstanding expectation.
    function void check_outcome(logic hit, logic pred_value);
      cache_outcome_t want;
      if (awaited_outcomes.size() == 0) begin
        complain($sformatf("unexpected result: expected none, actual hit %b pred_value %b",
                           hit, pred_value));
        return;
      end
      want = awaited_outcomes.pop_front();
      if (hit !== want.hit)
        complain($sformatf("hit mismatch: expected %b, actual %b", want.hit, hit));
      if (pred_value !== want.pred_value)
        complain($sformatf("pred_value mismatch: expected %b, actual %b",
                           want.pred_value, pred_value));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_cmd;
  logic [LOOP_W-1:0]    in_loop_key;
  logic [REG_IDX_W-1:0] in_reg_index;
  logic                 in_reg_is_bool;
  logic                 in_reg_bool_value;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_hit;
  logic                 out_pred_value;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_fastpath_enable;

  branch_cache_tracker tracker;

  // Flags shared between the stimulus and the result side. The stimulus raises
  // hold_request once; the result side then stalls on its own count.
  bit no_idle      = 1'b0;
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int cycle_count  = 0;

  // Small pools of keys, so that the well-formed traffic keeps returning to
  // the same sets: this is what produces hits, stale generations and evictions.
  logic [LOOP_W-1:0]    loop_pool [6];
  logic [REG_IDX_W-1:0] reg_pool  [20];

  predicate_branch_cache #(
    .BUCKETS  (BUCKETS),
    .WAYS     (WAYS),
    .REG_COUNT(REG_COUNT),
    .GEN_BITS (GEN_BITS)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_loop_key        (in_loop_key),
    .in_reg_index       (in_reg_index),
    .in_reg_is_bool     (in_reg_is_bool),
    .in_reg_bool_value  (in_reg_bool_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_pred_value     (out_pred_value),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_fastpath_enable(cfg_fastpath_enable)
  );

  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side. Signals are read just after the edge, before any register of
  // the block has taken its new value, so a transaction is seen exactly when
  // valid and ready were both high at that edge. Ready is then redrawn: low in
  // roughly a quarter of the cycles, never low during the quiet stretch, and
  // held low throughout a requested hold-off.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_outcome(out_hit, out_pred_value);
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  function automatic cache_cmd_t make_cmd(logic [CMD_W-1:0] cmd, logic [LOOP_W-1:0] loop_key,
                                          logic [REG_IDX_W-1:0] reg_index, logic is_bool,
                                          logic bool_value);
    cache_cmd_t c;
    c.cmd        = cmd;
    c.loop_key   = loop_key;
    c.reg_index  = reg_index;
    c.is_bool    = is_bool;
    c.bool_value = bool_value;
    return c;
  endfunction

  // Most commands are well formed and drawn from the key pools, with the type
  // tag usually set. The rest is noise: any code, unused ones included, any
  // loop and any register index, in range or far out of it.
  function automatic cache_cmd_t random_command();
    cache_cmd_t c;
    int         pick;
    c.bool_value = 1'($urandom_range(1));
    if ($urandom_range(99) < 85) begin
      pick = $urandom_range(99);
      if (pick < 40)      c.cmd = CMD_LOOKUP;
      else if (pick < 70) c.cmd = CMD_STORE;
      else if (pick < 80) c.cmd = CMD_BUMP;
      else if (pick < 98) c.cmd = CMD_TYPED;
      else                c.cmd = CMD_CLEAR;
      c.loop_key  = loop_pool[$urandom_range($size(loop_pool) - 1)];
      c.reg_index = reg_pool[$urandom_range($size(reg_pool) - 1)];
      c.is_bool   = $urandom_range(99) < 90;
    end else begin
      c.cmd       = CMD_W'($urandom_range(CMD_LAST));
      c.loop_key  = LOOP_W'($urandom());
      c.reg_index = $urandom_range(1) ? REG_IDX_W'($urandom())
                                      : REG_IDX_W'($urandom_range(REG_COUNT - 1));
      c.is_bool   = 1'($urandom_range(1));
    end
    return c;
  endfunction

  // Offers one transaction and returns at the edge where it is accepted, with
  // valid still high so that a following transaction can go straight on.
  task automatic send_cmd(cache_cmd_t c);
    if (!no_idle)
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid          <= 1'b1;
    in_cmd            <= c.cmd;
    in_loop_key       <= c.loop_key;
    in_reg_index      <= c.reg_index;
    in_reg_is_bool    <= c.is_bool;
    in_reg_bool_value <= c.bool_value;
    do @(posedge clk); while (!in_ready);
    tracker.note_command(c);
  endtask

  // Stops offering and waits until every outstanding result has arrived.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Configuration changes only with the block idle: drain, let the last
  // write-back settle, then write the register.
  task automatic reconfigure(bit enable);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid           <= 1'b1;
    cfg_fastpath_enable <= enable;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_fastpath(enable);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_fastpath_on();
    logic [LOOP_W-1:0]    clash_loop [5];
    logic [REG_IDX_W-1:0] clash_reg  [5];
    int                   target;
    int                   found;
    // Empty cache, then a store followed by a hit.
    send_cmd(make_cmd(CMD_LOOKUP, 16'h0000, 16'd0, 1'b1, 1'b1));
    send_cmd(make_cmd(CMD_STORE,  16'h0000, 16'd0, 1'b1, 1'b0));
    send_cmd(make_cmd(CMD_LOOKUP, 16'h0000, 16'd0, 1'b1, 1'b1));
    // Bumping the register makes the slot stale; the lookup then kills it.
    send_cmd(make_cmd(CMD_BUMP,   16'h0000, 16'd0, 1'b0, 1'b0));
    send_cmd(make_cmd(CMD_LOOKUP, 16'h0000, 16'd0, 1'b1, 1'b1));
    // Highest loop and register: a lookup of a non-bool register drops the slot.
    send_cmd(make_cmd(CMD_STORE,  16'hFFFF, 16'(REG_COUNT - 1), 1'b1, 1'b1));
    send_cmd(make_cmd(CMD_LOOKUP, 16'hFFFF, 16'(REG_COUNT - 1), 1'b0, 1'b1));
    send_cmd(make_cmd(CMD_LOOKUP, 16'hFFFF, 16'(REG_COUNT - 1), 1'b1, 1'b1));
    // Typed check: a bool register hits, any other misses and is bumped.
    send_cmd(make_cmd(CMD_TYPED,  16'h1234, 16'(REG_COUNT - 1), 1'b1, 1'b1));
    send_cmd(make_cmd(CMD_TYPED,  16'h1234, 16'(REG_COUNT - 1), 1'b0, 1'b1));
    // Out-of-range registers are never stored, found or bumped.
    send_cmd(make_cmd(CMD_STORE,  16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    send_cmd(make_cmd(CMD_LOOKUP, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    send_cmd(make_cmd(CMD_BUMP,   16'hFFFF, 16'(REG_COUNT), 1'b1, 1'b1));
    for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST; c++)
      send_cmd(make_cmd(CMD_W'(c), 16'h0000, 16'd0, 1'b1, 1'b1));
    send_cmd(make_cmd(CMD_CLEAR,  16'h0000, 16'd0, 1'b0, 1'b0));
    // Five keys that share one set: the fifth store must evict a way chosen by
    // its register number, and the lookups show which one went.
    target = tracker.set_base(16'h0000, 16'd1);
    found  = 0;
    for (int l = 0; l < 16 && found < 5; l++)
      for (int r = 0; r < REG_COUNT && found < 5; r++)
        if (tracker.set_base(LOOP_W'(l), REG_IDX_W'(r)) == target) begin
          clash_loop[found] = LOOP_W'(l);
          clash_reg[found]  = REG_IDX_W'(r);
          found++;
        end
    for (int k = 0; k < found; k++)
      send_cmd(make_cmd(CMD_STORE, clash_loop[k], clash_reg[k], 1'b1, 1'b0));
    for (int k = 0; k < found; k++)
      send_cmd(make_cmd(CMD_LOOKUP, clash_loop[k], clash_reg[k], 1'b1, 1'b1));
  endtask

  // With the fastpath off, lookups and typed checks miss and change nothing,
  // so the typed check on a non-bool register must not bump its generation.
  task automatic directed_fastpath_off();
    send_cmd(make_cmd(CMD_STORE,  16'h0001, 16'd1, 1'b1, 1'b1));
    send_cmd(make_cmd(CMD_LOOKUP, 16'h0001, 16'd1, 1'b1, 1'b1));
    send_cmd(make_cmd(CMD_TYPED,  16'h0001, 16'd1, 1'b0, 1'b1));
    send_cmd(make_cmd(CMD_TYPED,  16'h0001, 16'd1, 1'b1, 1'b1));
  endtask

  // Random traffic. With pressure on, the output side is made to hold off for
  // a long stretch while commands keep coming, a quiet stretch runs with no
  // idling on either side, and later the input waits for a full drain.
  task automatic random_phase(int count, bit pressure);
    loop_pool[0] = 16'h0000;
    loop_pool[1] = 16'hFFFF;
    for (int k = 2; k < $size(loop_pool); k++) loop_pool[k] = LOOP_W'($urandom());
    reg_pool[0] = 16'd0;
    reg_pool[1] = 16'(REG_COUNT - 1);
    for (int k = 2; k < $size(reg_pool); k++)
      reg_pool[k] = REG_IDX_W'($urandom_range(REG_COUNT - 1));
    for (int i = 0; i < count; i++) begin
      if (pressure) begin
        if (i == 30)  hold_request = 1'b1;
        if (i == 90)  no_idle = 1'b1;
        if (i == 190) no_idle = 1'b0;
        if (i == 230) wait_drain();
      end
      send_cmd(random_command());
    end
  endtask

  initial begin
    tracker = new();
    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_cmd              <= CMD_LOOKUP;
    in_loop_key         <= '0;
    in_reg_index        <= '0;
    in_reg_is_bool      <= 1'b0;
    in_reg_bool_value   <= 1'b0;
    out_ready           <= 1'b0;
    cfg_valid           <= 1'b0;
    cfg_fastpath_enable <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The clearing pass after reset is covered by waiting on in_ready.
    reconfigure(1'b1);
    directed_fastpath_on();
    reconfigure(1'b0);
    directed_fastpath_off();
    reconfigure(1'b1);
    random_phase(320, 1'b1);
    reconfigure(1'b0);
    random_phase(120, 1'b0);
    reconfigure(1'b1);
    random_phase(260, 1'b0);

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
